[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the rtl files that carry checks.
// Both macros use the clock clk and the synchronous reset rst of the including
// module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RLC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define RLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rlc_pkg.sv]
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and constants of the rectangle line clipper: register indexes,
// region code layout and the command and status words between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package rlc_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // configuration port
  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_X_MIN = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_X_MAX = 8'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_Y_MIN = 8'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIN_Y_MAX = 8'd3;

  // clipping passes per segment
  localparam int MAX_PASSES = 4;
  localparam int PASS_BITS  = 3;

  // stream word width for four coordinates, padded to whole bytes
  function automatic int coord_word_bits(input int w);
    return ((4 * w + 7) / 8) * 8;
  endfunction

  // region code of a point relative to the window
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } region_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // take a segment and latch the window
    logic setup;      // pick the edge, form differences and signs
    logic mul;        // register the magnitude product
    logic div_start;  // launch the divider
    logic update;     // move the outside point onto the edge
    logic emit;       // load the output register
    logic vis;        // visible flag for the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept;     // both points inside
    logic reject;     // both points beyond a common edge
    logic div_done;   // quotient ready
  } status_t;

endpackage

[hw/rtl/rlc_div.sv]
// ----------------------------------------------------------------------------
// rlc_div
// Restoring unsigned divider, one quotient bit per cycle. The quotient is
// known to fit W+1 bits, so the upper half of the dividend seeds the
// remainder and only W+1 steps are needed.
// ----------------------------------------------------------------------------
module rlc_div
  import rlc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2*W+1:0]   dividend,
  input  logic [W:0]       divisor,
  output logic             done,
  output logic [W:0]       quotient
);

  localparam int CNT_BITS = $clog2(W + 2);
  localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(W + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [W:0]          rem;
  logic [W:0]          qr;
  logic [W+1:0]        trial;
  logic [W+1:0]        diff;
  logic                fits;

  // shift one dividend bit into the remainder and try the subtraction
  assign trial = {rem, qr[W]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  assign done     = busy && (cnt == '0);
  assign quotient = qr;

  // control: busy flag and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= STEPS;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[2*W+1:W+1];
      qr  <= dividend[W:0];
    end else if (busy && (cnt != '0)) begin
      if (fits) begin
        rem <= diff[W:0];
      end else begin
        rem <= trial[W:0];
      end
      qr <= {qr[W-1:0], fits};
    end
  end

endmodule

[hw/rtl/rlc_dpath.sv]
// ----------------------------------------------------------------------------
// rlc_dpath
// Datapath of the line clipper: window registers, endpoint registers, region
// codes, edge selection, magnitude product, divider and the output register.
// ----------------------------------------------------------------------------
module rlc_dpath
  import rlc_pkg::*;
#(
  parameter int W = COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [W-1:0]                     cfg_data,
  // segment word
  input  logic [coord_word_bits(W)-1:0]    s_tdata,
  // result word
  output logic [coord_word_bits(W)-1:0]    m_tdata,
  output logic                             m_tuser,
  // controller link
  input  cmd_t                             cmd,
  output status_t                          st
);

  localparam int PW = 2 * W + 2;
  localparam int WB = coord_word_bits(W);

  // raw window registers as written
  logic signed [W-1:0] cfg_x_min, cfg_x_max, cfg_y_min, cfg_y_max;
  // normalized working window
  logic signed [W-1:0] wxl, wxh, wyl, wyh;
  // endpoints
  logic signed [W-1:0] x1, y1, x2, y2;
  region_t             c1, c2, csel;

  // setup results
  logic signed [W-1:0] sel_a, sel_b, sel_c, sel_d, sel_e;
  logic signed [W:0]   span, num, den;
  logic                sel_y;
  logic                mv_p1, mv_y, neg;
  logic signed [W-1:0] edge_val, base;
  logic [W:0]          mag_span, mag_num, mag_den;
  logic [PW-1:0]       prod_full, prod;

  // divider and move
  logic                div_done;
  logic [W:0]          quo;
  logic [W+1:0]        base_ext, quo_ext, moved;
  logic signed [W-1:0] new_c;

  // output register
  logic signed [W-1:0] o_x1, o_y1, o_x2, o_y2;
  logic                o_vis;

  function automatic region_t region_of(input logic signed [W-1:0] x,
                                        input logic signed [W-1:0] y,
                                        input logic signed [W-1:0] xl,
                                        input logic signed [W-1:0] xh,
                                        input logic signed [W-1:0] yl,
                                        input logic signed [W-1:0] yh);
    region_t r;
    r.top    = y > yh;
    r.bottom = !r.top && (y < yl);
    r.left   = x < xl;
    r.right  = !r.left && (x > xh);
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_x_min <= {1'b1, {(W-1){1'b0}}};
      cfg_x_max <= {1'b0, {(W-1){1'b1}}};
      cfg_y_min <= {1'b1, {(W-1){1'b0}}};
      cfg_y_max <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIN_X_MIN: cfg_x_min <= cfg_data;
        REG_WIN_X_MAX: cfg_x_max <= cfg_data;
        REG_WIN_Y_MIN: cfg_y_min <= cfg_data;
        REG_WIN_Y_MAX: cfg_y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // region codes and controller status
  assign c1 = region_of(x1, y1, wxl, wxh, wyl, wyh);
  assign c2 = region_of(x2, y2, wxl, wxh, wyl, wyh);
  assign st.accept   = (c1 | c2) == '0;
  assign st.reject   = (c1 & c2) != '0;
  assign st.div_done = div_done;

  // edge selection: outside start point first, then top, bottom, left, right
  always_comb begin
    csel  = (c1 != '0) ? c1 : c2;
    sel_y = csel.top || csel.bottom;
    if (csel.top) begin
      sel_e = wyh;
    end else if (csel.bottom) begin
      sel_e = wyl;
    end else if (csel.left) begin
      sel_e = wxl;
    end else begin
      sel_e = wxh;
    end
    if (sel_y) begin
      sel_a = x1;
      sel_b = x2;
      sel_c = y1;
      sel_d = y2;
    end else begin
      sel_a = y1;
      sel_b = y2;
      sel_c = x1;
      sel_d = x2;
    end
    span = {sel_b[W-1], sel_b} - {sel_a[W-1], sel_a};
    num  = {sel_e[W-1], sel_e} - {sel_c[W-1], sel_c};
    den  = {sel_d[W-1], sel_d} - {sel_c[W-1], sel_c};
  end

  // segment load, setup, product and point move
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x1  <= s_tdata[0*W +: W];
      y1  <= s_tdata[1*W +: W];
      x2  <= s_tdata[2*W +: W];
      y2  <= s_tdata[3*W +: W];
      wxl <= (cfg_x_min > cfg_x_max) ? cfg_x_max : cfg_x_min;
      wxh <= (cfg_x_min > cfg_x_max) ? cfg_x_min : cfg_x_max;
      wyl <= (cfg_y_min > cfg_y_max) ? cfg_y_max : cfg_y_min;
      wyh <= (cfg_y_min > cfg_y_max) ? cfg_y_min : cfg_y_max;
    end else if (cmd.update) begin
      if (mv_p1) begin
        x1 <= mv_y ? new_c : edge_val;
        y1 <= mv_y ? edge_val : new_c;
      end else begin
        x2 <= mv_y ? new_c : edge_val;
        y2 <= mv_y ? edge_val : new_c;
      end
    end
    if (cmd.setup) begin
      mv_p1    <= c1 != '0;
      mv_y     <= sel_y;
      edge_val <= sel_e;
      base     <= sel_a;
      neg      <= span[W] ^ num[W] ^ den[W];
      mag_span <= span[W] ? (~span + 1'b1) : span;
      mag_num  <= num[W] ? (~num + 1'b1) : num;
      mag_den  <= den[W] ? (~den + 1'b1) : den;
    end
    if (cmd.mul) begin
      prod <= prod_full;
    end
  end

  // exact magnitude product
  assign prod_full = mag_span * mag_num;

  rlc_div #(
    .W (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (mag_den),
    .done     (div_done),
    .quotient (quo)
  );

  // base plus or minus the truncated quotient
  assign base_ext = {{2{base[W-1]}}, base};
  assign quo_ext  = {1'b0, quo};
  assign moved    = neg ? (base_ext - quo_ext) : (base_ext + quo_ext);
  assign new_c    = moved[W-1:0];

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_vis <= cmd.vis;
      o_x1  <= x1;
      o_y1  <= y1;
      o_x2  <= x2;
      o_y2  <= y2;
    end
  end

  assign m_tdata = WB'({o_y2, o_x2, o_y1, o_x1});
  assign m_tuser = o_vis;

endmodule

[hw/rtl/rlc_ctrl.sv]
// ----------------------------------------------------------------------------
// rlc_ctrl
// Controller of the line clipper: sequences load, region checks, up to four
// clipping passes and the hand-off to the output register.
// ----------------------------------------------------------------------------
module rlc_ctrl
  import rlc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  logic    m_tready,
  output logic    m_tvalid,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_SETUP = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_DIVS  = 8'b0001_0000,
    ST_DIVW  = 8'b0010_0000,
    ST_UPD   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t               state, state_next;
  logic [PASS_BITS-1:0] pass;
  logic                 vis, vis_next;
  logic                 out_free;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = state == ST_IDLE;

  // next state and commands
  always_comb begin
    state_next = state;
    vis_next   = vis;
    cmd        = '0;
    cmd.vis    = vis;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.accept) begin
          vis_next   = 1'b1;
          state_next = ST_FIN;
        end else if (st.reject || (pass == PASS_BITS'(MAX_PASSES))) begin
          vis_next   = 1'b0;
          state_next = ST_FIN;
        end else begin
          state_next = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIVW;
      end
      ST_DIVW: begin
        if (st.div_done) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state, pass count, visible flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pass  <= '0;
      vis   <= 1'b0;
    end else begin
      state <= state_next;
      vis   <= vis_next;
      if (cmd.load) begin
        pass <= '0;
      end else if (cmd.update) begin
        pass <= pass + 1'b1;
      end
    end
  end

  // output word valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

[hw/rtl/rectangle_line_clipper.sv]
// ----------------------------------------------------------------------------
// rectangle_line_clipper
// Cohen-Sutherland clipping of one segment per input word against a
// configurable rectangular window.
//
//   channel  direction  handshake              payload
//   s_       in         s_tvalid / s_tready    s_tdata: start_x, start_y, end_x, end_y
//   m_       out        m_tvalid / m_tready    m_tdata: clipped coords, m_tuser: visible
//   cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An accepted or rejected segment with no move goes from the load through the
// region check to the output register; each clipping pass adds setup, product,
// divider start, divider wait and point update, the divider yielding one
// quotient bit per cycle. There are up to four passes per segment.
// One segment is in work at a time; the next is taken while a result waits.
// Reset (rst, synchronous) restores the full-range window and empties the
// output register. A stalled output holds the finished segment in its last
// state until the output register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rectangle_line_clipper
  import rlc_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // segment in, from bit 0: start_x, start_y, end_x, end_y, zero padding
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [coord_word_bits(COORD_BITS)-1:0] s_tdata,
  // result out, from bit 0: clipped_start_x, clipped_start_y,
  // clipped_end_x, clipped_end_y, zero padding
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [coord_word_bits(COORD_BITS)-1:0] m_tdata,
  // visible
  output logic                                   m_tuser,
  // window register writes
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
  input  logic [COORD_BITS-1:0]                  cfg_data
);

  cmd_t    cmd;
  status_t st;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  rlc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .st       (st),
    .cmd      (cmd)
  );

  rlc_dpath #(
    .W (COORD_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .st        (st)
  );

  // checks
  `RLC_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "segment taken while busy")
  `RLC_ASSERT_IMPL(a_emit_into_free, cmd.emit, !m_tvalid || m_tready, "output word overwritten")
  `RLC_ASSERT_IMPL(a_move_after_div, cmd.update, $past(st.div_done), "point moved before quotient")
  `RLC_ASSERT_IMPL(a_valid_from_emit, $rose(m_tvalid), $past(cmd.emit), "output valid without result")

endmodule
